### rtl/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_MS_RST     = 16'd50;
  localparam logic [15:0] LONG_HOLD_MS_RST    = 16'd1000;
  localparam logic [15:0] DOUBLE_CLICK_MS_RST = 16'd300;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;

  // Register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_LONG_PRESS   = 2'd1,
    CFG_DOUBLE_CLICK = 2'd2
  } cfg_idx_e;

  // Event codes reported with each sample
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] long_hold_ms;
    logic [CFG_DATA_W-1:0] double_click_ms;
  } cfg_t;

  // Classifier state carried from one sample to the next
  typedef struct packed {
    logic              previous_raw;
    logic              debounced_level;
    logic              long_fired;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] last_click_time;
  } state_t;

  localparam state_t STATE_RST = '{
    previous_raw:    1'b1,
    debounced_level: 1'b1,
    long_fired:      1'b0,
    change_time:     '0,
    press_time:      '0,
    last_click_time: '0
  };

endpackage

`default_nettype wire

### rtl/bcc_if.sv
`default_nettype none

// Sample channel: one button sample with its timestamp per beat
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic        raw_level;
  logic [31:0] now_ms;

  modport source (output valid, raw_level, now_ms, input ready);
  modport sink   (input valid, raw_level, now_ms, output ready);
endinterface

// Result channel: one event code and debounced level per beat
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic       stable_level;

  modport source (output valid, event_kind, stable_level, input ready);
  modport sink   (input valid, event_kind, stable_level, output ready);
endinterface

`default_nettype wire

### rtl/bcc_cfg_regs.sv
`default_nettype none

module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:     cfg_d.debounce_ms     = cfg_wdata_i;
        CFG_LONG_PRESS:   cfg_d.long_hold_ms    = cfg_wdata_i;
        CFG_DOUBLE_CLICK: cfg_d.double_click_ms = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DEBOUNCE_MS_RST;
      cfg_q.long_hold_ms    <= LONG_HOLD_MS_RST;
      cfg_q.double_click_ms <= DOUBLE_CLICK_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/bcc_core.sv
`default_nettype none

module bcc_core
  import bcc_pkg::*;
(
  input  wire cfg_t         cfg_i,
  input  wire state_t       state_i,
  input  wire               raw_level_i,
  input  wire [TIME_W-1:0]  now_ms_i,
  output state_t            state_o,
  output event_kind_e       event_kind_o
);

  logic              raw_changed;
  logic [TIME_W-1:0] held_ms;
  logic [TIME_W-1:0] hold_ms;
  logic [TIME_W-1:0] gap_ms;
  logic              level_accepted;
  logic              long_reached;
  state_t            st;
  event_kind_e       ev;

  always_comb begin
    st = state_i;
    ev = EV_NONE;

    // Restart the debounce window on any raw edge
    raw_changed = raw_level_i != state_i.previous_raw;
    if (raw_changed) begin
      st.change_time = now_ms_i;
    end
    held_ms = now_ms_i - st.change_time;
    level_accepted = (held_ms > {16'b0, cfg_i.debounce_ms})
                     && (raw_level_i != state_i.debounced_level);

    // Press start: time is unchanged at release, so one subtractor serves both
    if (level_accepted && !raw_level_i) begin
      st.press_time = now_ms_i;
      st.long_fired = 1'b0;
    end
    hold_ms      = now_ms_i - st.press_time;
    long_reached = hold_ms >= {16'b0, cfg_i.long_hold_ms};
    gap_ms       = now_ms_i - state_i.last_click_time;

    // Accepted level change and release classification
    if (level_accepted) begin
      st.debounced_level = raw_level_i;
      if (raw_level_i && !state_i.long_fired) begin
        if (long_reached) begin
          ev = EV_LONG;
        end else begin
          ev = (gap_ms < {16'b0, cfg_i.double_click_ms}) ? EV_DOUBLE : EV_SINGLE;
          st.last_click_time = now_ms_i;
        end
      end
    end

    // Long press while still held
    if (!st.debounced_level && !st.long_fired && long_reached) begin
      st.long_fired = 1'b1;
      ev = EV_LONG;
    end

    st.previous_raw = raw_level_i;
  end

  assign state_o      = st;
  assign event_kind_o = ev;

endmodule

`default_nettype wire

### rtl/button_click_classifier_unit.sv
// Button click classifier: debounces an active-low button sample stream and
// reports one result beat per sample beat: the event code (none, single click,
// double click, long press) and the debounced level after that sample. Beats
// are taken one per clock while the result side keeps up, via the sample register
// and then the result register; the rate is set by the state update loop through
// the classifier logic. A waiting result stops the next sample only once the
// sample register is full. The user must write registers on the plain write port
// only while no beat is in flight; the block does not enforce it. Index 3 is ignored.
`default_nettype none

module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  bcc_in_if.sink               in_i,
  bcc_out_if.source            out_o
);

  cfg_t              cfg;
  state_t            state_q, state_d;
  event_kind_e       event_kind_d;

  logic              s1_valid_q;
  logic              s1_raw_q;
  logic [TIME_W-1:0] s1_now_q;
  logic              s1_advance;

  logic              res_valid_q;
  event_kind_e       res_event_q;
  logic              res_level_q;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcc_core u_core (
    .cfg_i        (cfg),
    .state_i      (state_q),
    .raw_level_i  (s1_raw_q),
    .now_ms_i     (s1_now_q),
    .state_o      (state_d),
    .event_kind_o (event_kind_d)
  );

  // Handshake: sample stage moves on whenever the result slot is free
  assign s1_advance = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_raw_q <= in_i.raw_level;
      s1_now_q <= in_i.now_ms;
    end
  end

  // Classifier state, updated once per sample beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (s1_advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      res_event_q <= event_kind_d;
      res_level_q <= state_d.debounced_level;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.event_kind   = res_event_q;
  assign out_o.stable_level = res_level_q;

  // Clicks are only reported on a release
  a_click_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_event_q == EV_SINGLE || res_event_q == EV_DOUBLE)
      |-> res_level_q)
    else $error("click reported while button held");

  // A long press reported while held leaves the fired flag set
  a_long_marks_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_event_q == EV_LONG && !res_level_q |-> state_q.long_fired)
    else $error("long press while held without fired flag");

  // A pending result reflects the latest state update
  a_level_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_level_q == state_q.debounced_level)
    else $error("result level differs from debounced state");

  // An accepted sample is registered on the next edge
  a_sample_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_valid_q)
    else $error("accepted sample lost");

endmodule

`default_nettype wire

### sim/testbench.sv
module testbench;
  import bcc_pkg::*;

  // Index with no register behind it; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned HOLDOFF_CYCLES = 60;
  localparam int unsigned HOLDOFF_AT     = 460;

  typedef struct packed {
    logic        level;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    event_kind_e kind;
    logic        stable;
  } verdict_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bcc_in_if  smp_bus ();
  bcc_out_if res_bus ();

  button_click_classifier_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (smp_bus),
    .out_o       (res_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the registers and the classifier state
  logic [15:0] db_ms = DEBOUNCE_MS_RST;
  logic [15:0] lp_ms = LONG_HOLD_MS_RST;
  logic [15:0] dc_ms = DOUBLE_CLICK_MS_RST;
  logic        last_raw  = 1'b1;
  logic        settled   = 1'b1;
  logic        long_done = 1'b0;
  logic [31:0] toggle_ms = '0;
  logic [31:0] press_ms  = '0;
  logic [31:0] click_ms  = '0;

  sample_t     pending_samples[$];
  verdict_t    due_verdicts[$];
  logic [31:0] clock_ms = '0;

  int unsigned issued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned result_cnt = 0;
  int unsigned err_cnt    = 0;
  int unsigned n_single   = 0;
  int unsigned n_double   = 0;
  int unsigned n_long     = 0;
  int unsigned n_settings = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holdoff_left = 0;
  logic        holdoff_done = 1'b0;

  // no random gaps on either side in this window
  wire calm = (taken_cnt >= 540) && (taken_cnt < 640);

  // Debounce and click classification for one sample; updates the shadow state
  function automatic verdict_t classify(input sample_t s);
    verdict_t    v;
    logic [31:0] since_toggle, since_press, since_click;
    v.kind = EV_NONE;
    if (s.level != last_raw) toggle_ms = s.stamp;
    since_toggle = s.stamp - toggle_ms;
    if (since_toggle > {16'd0, db_ms} && s.level != settled) begin
      settled = s.level;
      if (!s.level) begin
        press_ms  = s.stamp;
        long_done = 1'b0;
      end else if (!long_done) begin
        since_press = s.stamp - press_ms;
        since_click = s.stamp - click_ms;
        if (since_press >= {16'd0, lp_ms}) begin
          v.kind = EV_LONG;
        end else begin
          v.kind   = (since_click < {16'd0, dc_ms}) ? EV_DOUBLE : EV_SINGLE;
          click_ms = s.stamp;
        end
      end
    end
    // long press seen while still held
    since_press = s.stamp - press_ms;
    if (!settled && !long_done && since_press >= {16'd0, lp_ms}) begin
      long_done = 1'b1;
      v.kind    = EV_LONG;
    end
    last_raw = s.level;
    v.stable = settled;
    return v;
  endfunction

  // Sample driver: holds a beat until taken, then loads the next one
  always @(negedge clk_i) begin
    sample_t nxt;
    if (rst_ni && (!smp_bus.valid || taken_cnt == issued_cnt)) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        nxt = pending_samples.pop_front();
        smp_bus.valid     <= 1'b1;
        smp_bus.raw_level <= nxt.level;
        smp_bus.now_ms    <= nxt.stamp;
        issued_cnt++;
      end else begin
        smp_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (holdoff_left != 0) begin
        holdoff_left--;
        res_bus.ready <= 1'b0;
      end else if (!holdoff_done && result_cnt >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= calm || $urandom_range(99) >= 6;
      end
    end
  end

  // Monitor: predict on every sample beat, check every result beat
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (smp_bus.valid && smp_bus.ready) begin
        due_verdicts.push_back(classify(sample_t'{smp_bus.raw_level, smp_bus.now_ms}));
        taken_cnt++;
      end
      if (res_bus.valid && res_bus.ready) begin
        result_cnt++;
        if (due_verdicts.size() == 0) begin
          $error("result beat with no sample pending: event_kind %0d stable_level %0d",
                 res_bus.event_kind, res_bus.stable_level);
          err_cnt++;
        end else begin
          want = due_verdicts.pop_front();
          if (res_bus.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, res_bus.event_kind);
            err_cnt++;
          end
          if (res_bus.stable_level !== want.stable) begin
            $error("stable_level: expected %0d, actual %0d", want.stable,
                   res_bus.stable_level);
            err_cnt++;
          end
          case (want.kind)
            EV_SINGLE: n_single++;
            EV_DOUBLE: n_double++;
            EV_LONG:   n_long++;
            default: ;
          endcase
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("button_click_classifier_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE:     db_ms = val;
      CFG_LONG_PRESS:   lp_ms = val;
      CFG_DOUBLE_CLICK: dc_ms = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] db, input logic [15:0] lp,
                                input logic [15:0] dc);
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_DOUBLE_CLICK, dc);
    write_reg(CFG_SPARE, 16'($urandom()));
    @(negedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Wait until every sample is taken and every result has come back
  task automatic settle();
    while (pending_samples.size() != 0 || taken_cnt != issued_cnt ||
           due_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_at(input logic lvl, input logic [31:0] t);
    clock_ms = t;
    pending_samples.push_back(sample_t'{lvl, t});
  endtask

  task automatic put(input logic lvl, input int unsigned dt);
    put_at(lvl, clock_ms + dt);
  endtask

  // Span around a threshold: below it, right at it, or well past it
  function automatic int unsigned pick_span(input int unsigned mark);
    case ($urandom_range(2))
      0: return $urandom_range(mark);
      1: return mark - ((mark >= 3) ? 3 : mark) + $urandom_range(6);
      default: return mark + $urandom_range(2 * mark + 10);
    endcase
  endfunction

  // Contact bounce that settles on lvl, each toggle no longer than the debounce time
  task automatic bounce_to(input logic lvl);
    int unsigned k;
    k = $urandom_range(3);
    repeat (k) begin
      put(lvl, $urandom_range(db_ms));
      put(!lvl, $urandom_range(db_ms));
    end
    put(lvl, $urandom_range(db_ms));
  endtask

  // Level held long enough to be accepted, then for span more ms
  task automatic steady(input logic lvl, input int unsigned span);
    int unsigned n, k;
    n = $urandom_range(1, 4);
    put(lvl, db_ms + 1 + $urandom_range(1));
    for (k = 1; k <= n; k++)
      put(lvl, span / n + ((k == n) ? span % n : 0));
  endtask

  task automatic gesture();
    bounce_to(1'b0);
    steady(1'b0, pick_span(lp_ms));
    bounce_to(1'b1);
    steady(1'b1, pick_span(dc_ms));
  endtask

  // Mostly clean press/release gestures, some noise and glitches
  task automatic fill(input int unsigned n_items);
    int unsigned goal, pick;
    goal = pending_samples.size() + n_items;
    while (pending_samples.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        gesture();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1)) put_at(1'($urandom_range(1)), $urandom());
          else put(1'($urandom_range(1)), $urandom_range(3));
        end
      end else begin
        bounce_to(1'b0);
        bounce_to(1'b1);
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] db, input logic [15:0] lp,
                           input logic [15:0] dc, input int unsigned n_items);
    apply_settings(db, lp, dc);
    fill(n_items);
    settle();
  endtask

  initial begin
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DEBOUNCE;
    cfg_wdata         = '0;
    smp_bus.valid     = 1'b0;
    smp_bus.raw_level = 1'b1;
    smp_bus.now_ms    = '0;
    res_bus.ready     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: first click right after time zero is a double
    put_at(1'b0, 32'd0);
    put_at(1'b0, 32'd51);
    put_at(1'b1, 32'd100);
    put_at(1'b1, 32'd151);
    // long press fires while held, release stays silent
    put_at(1'b0, 32'd200);
    put_at(1'b0, 32'd260);
    put_at(1'b0, 32'd1260);
    put_at(1'b1, 32'd1300);
    put_at(1'b1, 32'd1400);
    // long press only recognized at release
    put_at(1'b0, 32'd2000);
    put_at(1'b0, 32'd2100);
    put_at(1'b1, 32'd2500);
    put_at(1'b1, 32'd3200);
    // single click then a quick second one
    put_at(1'b0, 32'd5000);
    put_at(1'b0, 32'd5100);
    put_at(1'b1, 32'd5200);
    put_at(1'b1, 32'd5300);
    put_at(1'b0, 32'd5350);
    put_at(1'b0, 32'd5420);
    put_at(1'b1, 32'd5450);
    put_at(1'b1, 32'd5520);
    // time running backwards and across the wrap
    put_at(1'b0, 32'd100);
    put_at(1'b0, 32'hFFFF_FFFF);
    put_at(1'b1, 32'd0);
    put_at(1'b1, 32'h7FFF_FFFF);
    settle();

    run_phase(DEBOUNCE_MS_RST, LONG_HOLD_MS_RST, DOUBLE_CLICK_MS_RST, 140);
    run_phase(16'd0, 16'd1, 16'd0, 90);
    clock_ms = 32'hFFFF_FFFF - $urandom_range(200000);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 70);
    // long-press time of zero fires on the accepted press itself
    run_phase(16'd5, 16'd0, 16'd40, 60);
    clock_ms = $urandom();
    run_phase(16'($urandom_range(20)), 16'($urandom_range(1, 300)),
              16'($urandom_range(200)), 150);
    run_phase(16'($urandom_range(20)), 16'($urandom_range(1, 300)),
              16'($urandom_range(200)), 140);

    $display("%0d samples and %0d results over %0d register settings",
             taken_cnt, result_cnt, n_settings);
    $display("events seen: %0d single, %0d double, %0d long press",
             n_single, n_double, n_long);
    if (err_cnt == 0) begin
      $display("button_click_classifier_unit verification clean");
    end else begin
      $display("button_click_classifier_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bcc_pkg.sv
rtl/bcc_if.sv
rtl/bcc_cfg_regs.sv
rtl/bcc_core.sv
rtl/button_click_classifier_unit.sv
sim/testbench.sv
